// ===== hdl/dpp_pkg.sv =====
// Package with the word types, register indexes and reset values of the depth back-projector.
`timescale 1ns / 1ps
package dpp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENTER_X  = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [2:0] CFG_FOCAL_X   = 3'd2;
  localparam logic [2:0] CFG_FOCAL_Y   = 3'd3;
  localparam logic [2:0] CFG_MAX_DEPTH = 3'd4;

  // Reset values of the registers.
  localparam logic [15:0] RST_CENTER_X  = 16'd10240;
  localparam logic [15:0] RST_CENTER_Y  = 16'd5760;
  localparam logic [15:0] RST_FOCAL_X   = 16'd8400;
  localparam logic [15:0] RST_FOCAL_Y   = 16'd8400;
  localparam logic [15:0] RST_MAX_DEPTH = 16'd5000;

  localparam int DEPTH_BITS_DEF = 16;

  // Input word: one depth pixel.
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] depth_mm;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_last;
  } pixel_t;

  // Output word: one body-frame point.
  typedef struct packed {
    logic [15:0]        forward_mm;
    logic signed [31:0] left_mm;
    logic signed [31:0] up_mm;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic               point_valid;
    logic               frame_end;
  } point_t;

  // Negate and saturate a truncated quotient into a signed 32-bit pattern.
  function automatic logic [31:0] lat_sat(input logic [63:0] q, input logic neg);
    logic [63:0] s;
    begin
      if (neg) begin
        s = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
      end else begin
        s = (q > 64'h8000_0000) ? 64'h8000_0000 : q;
        s = 64'd0 - s;
      end
      lat_sat = s[31:0];
    end
  endfunction

endpackage

// ===== hdl/depth_pixel_to_point.sv =====
// Top level of the pinhole depth back-projector: one pixel in, at most one point out.
//
//   channel | direction | handshake            | word
//   in_     | input     | in_valid / in_ready  | pixel_t
//   out_    | output    | out_valid / out_ready| point_t
//   cfg_    | input     | cfg_we               | 16-bit register data
//
// One pixel is accepted per cycle while no result waits at the output. The pipeline
// length is set by the restoring divider that retires one quotient bit per stage.
// Reset clears every stage valid bit and loads the register reset values.
// A waiting result freezes the whole pipeline; dropped pixels become bubbles unless they carry frame_last.
`timescale 1ns / 1ps
module depth_pixel_to_point #(
  parameter int DEPTH_BITS = dpp_pkg::DEPTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dpp_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dpp_pkg::point_t out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_wdata
);
  import dpp_pkg::*;

  localparam int DW = (DEPTH_BITS < 16) ? DEPTH_BITS : 16;
  localparam int NW = 16 + DW;
  localparam int NS = NW + 2;

  typedef struct packed {
    logic          pv;
    logic          last;
    logic [DW-1:0] d;
    logic [23:0]   rgb;
    logic          negx;
    logic          negy;
    logic [NW-1:0] numx;
    logic [NW-1:0] numy;
    logic [15:0]   remx;
    logic [15:0]   remy;
  } stage_t;

  logic [15:0] cx_r, cy_r, fx_r, fy_r, maxd_r;
  logic [15:0] fx_eff, fy_eff;
  logic        vld_r [NS];
  stage_t      st_r [NS];
  stage_t      st_nxt [NS];
  logic        outv_r;
  point_t      out_r, out_nxt;
  logic        en;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= RST_CENTER_X;
      cy_r   <= RST_CENTER_Y;
      fx_r   <= RST_FOCAL_X;
      fy_r   <= RST_FOCAL_Y;
      maxd_r <= RST_MAX_DEPTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X:  cx_r   <= cfg_wdata;
        CFG_CENTER_Y:  cy_r   <= cfg_wdata;
        CFG_FOCAL_X:   fx_r   <= cfg_wdata;
        CFG_FOCAL_Y:   fy_r   <= cfg_wdata;
        CFG_MAX_DEPTH: maxd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A zero focal length divides as one.
  assign fx_eff = (fx_r == 16'd0) ? 16'd1 : fx_r;
  assign fy_eff = (fy_r == 16'd0) ? 16'd1 : fy_r;

  // The whole pipeline moves unless a result waits at the output.
  assign en        = !outv_r || out_ready;
  assign in_ready  = en;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  always_comb begin
    logic [15:0] p16x, p16y;
    logic [DW-1:0] dd;
    logic [16:0] tx, ty;
    p16x = {in_data.column, 4'b0000};
    p16y = {in_data.row, 4'b0000};
    dd   = in_data.depth_mm[DW-1:0];

    // Stage 0: range check and signed offsets from the principal point.
    st_nxt[0]      = '0;
    st_nxt[0].pv   = (dd != '0) && ({{(16-DW){1'b0}}, dd} <= maxd_r);
    st_nxt[0].last = in_data.frame_last;
    st_nxt[0].d    = dd;
    st_nxt[0].rgb  = {in_data.red, in_data.green, in_data.blue};
    st_nxt[0].negx = p16x < cx_r;
    st_nxt[0].negy = p16y < cy_r;
    st_nxt[0].numx = {{DW{1'b0}}, (st_nxt[0].negx ? cx_r - p16x : p16x - cx_r)};
    st_nxt[0].numy = {{DW{1'b0}}, (st_nxt[0].negy ? cy_r - p16y : p16y - cy_r)};

    // Stage 1: offset times depth.
    st_nxt[1]      = st_r[0];
    st_nxt[1].numx = NW'(st_r[0].numx[15:0] * st_r[0].d);
    st_nxt[1].numy = NW'(st_r[0].numy[15:0] * st_r[0].d);
    st_nxt[1].remx = '0;
    st_nxt[1].remy = '0;

    // Divider stages: one restoring step each, quotient shifts into the numerator.
    for (int k = 2; k < NS; k++) begin
      st_nxt[k] = st_r[k-1];
      tx = {st_r[k-1].remx, st_r[k-1].numx[NW-1]};
      ty = {st_r[k-1].remy, st_r[k-1].numy[NW-1]};
      if (tx >= {1'b0, fx_eff}) begin
        st_nxt[k].remx = 16'(tx - {1'b0, fx_eff});
        st_nxt[k].numx = {st_r[k-1].numx[NW-2:0], 1'b1};
      end else begin
        st_nxt[k].remx = tx[15:0];
        st_nxt[k].numx = {st_r[k-1].numx[NW-2:0], 1'b0};
      end
      if (ty >= {1'b0, fy_eff}) begin
        st_nxt[k].remy = 16'(ty - {1'b0, fy_eff});
        st_nxt[k].numy = {st_r[k-1].numy[NW-2:0], 1'b1};
      end else begin
        st_nxt[k].remy = ty[15:0];
        st_nxt[k].numy = {st_r[k-1].numy[NW-2:0], 1'b0};
      end
    end

    // Output stage: negate, saturate, zero the coordinates of a dropped point.
    out_nxt = '0;
    if (st_r[NS-1].pv) begin
      out_nxt.forward_mm = {{(16-DW){1'b0}}, st_r[NS-1].d};
      out_nxt.left_mm    = lat_sat({{(64-NW){1'b0}}, st_r[NS-1].numx}, st_r[NS-1].negx);
      out_nxt.up_mm      = lat_sat({{(64-NW){1'b0}}, st_r[NS-1].numy}, st_r[NS-1].negy);
    end
    out_nxt.out_red     = st_r[NS-1].rgb[23:16];
    out_nxt.out_green   = st_r[NS-1].rgb[15:8];
    out_nxt.out_blue    = st_r[NS-1].rgb[7:0];
    out_nxt.point_valid = st_r[NS-1].pv;
    out_nxt.frame_end   = st_r[NS-1].last;
  end

  // Stage valid bits; a dropped pixel enters as a bubble unless it carries frame_last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
      outv_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid && (st_nxt[0].pv || in_data.frame_last);
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
      outv_r <= vld_r[NS-1];
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) st_r[k] <= st_nxt[k];
      out_r <= out_nxt;
    end
  end

endmodule
